/* hdl/slsh_pkg.sv */
package slsh_pkg;

    localparam int LINE_MAX   = 2048;
    localparam int COL_W      = $clog2(LINE_MAX);
    localparam int CNT_W      = COL_W + 1;
    localparam int SRC_W      = COL_W + 2;
    localparam int REG_W      = 12;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int DEPTH_W    = 8;
    localparam int DEPTH_SHIFT = 3;
    localparam int FIFO_DEPTH = 3;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [REG_W-1:0] PATTERN_WIDTH_RESET = 12'd64;
    localparam logic [REG_W-1:0] LINE_WIDTH_RESET    = 12'd512;

    // register select is paddr[2]
    localparam logic REG_IDX_PATTERN_WIDTH = 1'b0;
    localparam logic REG_IDX_LINE_WIDTH    = 1'b1;

    // color word: red in the low byte, then green, then blue
    typedef struct packed {
        logic              last;
        logic [COLOR_W-1:0] color;
    } out_item_t;

endpackage

/* hdl/slsh_ram.sv */
module slsh_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/slsh_out_fifo.sv */
module slsh_out_fifo (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            push,
    input  slsh_pkg::out_item_t             push_item,
    output logic [slsh_pkg::FIFO_CNT_W-1:0] level,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output slsh_pkg::out_item_t             head_item
);
    import slsh_pkg::*;

    out_item_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_PTR_W-1:0]   wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign level     = count_reg;
    assign m_tvalid  = (count_reg != '0);
    assign head_item = entry_reg[rd_ptr_reg];

endmodule

/* hdl/stereogram_line_shift.sv */
// stereogram_line_shift: per-line autostereogram pixel shifter
// pixels enter on the s_ stream in raster order, one transfer per pixel;
// each output pixel leaves on the m_ stream with tlast on the last pixel of a line.
// the first pattern_width columns of a line pass the pattern color; later columns
// repeat the stored color at column - pattern_width + depth/8, limited to column - 1.
// two registers on the apb port: pattern_width at 0x0, line_width at 0x4.
// throughput: one pixel per clock while m_tready stays high; the line store is one
// 2048 x 24 ram with one write and one read port, read issued at the input transfer.
// an accepted pixel is registered in the s1 stage, then pushed into the output
// queue, and is offered on m_ from the head of that queue.
// the read-after-write hazard on the column just written is covered by forwarding.
// results sit in a three-entry output queue: when the receiver stalls the queue
// fills, and s_tready drops only once it and the pipeline stage hold three pixels.
// reset clears the column counter, the pipeline and the queue and loads the
// registers with 64 and 512; the line store needs no clearing since every
// column is written before it is read.
module stereogram_line_shift (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // depth, pattern_red, pattern_green, pattern_blue
    // output pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_red, out_green, out_blue
    output logic        m_tlast    // end_of_line
);
    import slsh_pkg::*;

    logic [REG_W-1:0]   pattern_width_reg;
    logic [REG_W-1:0]   line_width_reg;
    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_pattern_reg;
    logic               s1_fwd_reg;
    logic               s1_last_reg;
    logic [COLOR_W-1:0] s1_pat_color_reg;
    logic [COLOR_W-1:0] last_color_reg;

    logic               cfg_write;
    logic               in_xfer;
    logic [CNT_W-1:0]   lw_eff;
    logic [REG_W-1:0]   pw_nz;
    logic [CNT_W-1:0]   pw_eff;
    logic [DEPTH_W-1:0] in_depth;
    logic [COLOR_W-1:0] in_color;
    logic               use_pattern;
    logic               is_last;
    logic [SRC_W-1:0]   src_sum;
    logic [COL_W-1:0]   src_addr;
    logic               fwd_hit;
    logic [COLOR_W-1:0] rd_color;
    logic [COLOR_W-1:0] s1_color;
    out_item_t          push_item;
    out_item_t          head_item;
    logic [FIFO_CNT_W-1:0] fifo_level;
    logic [FIFO_CNT_W:0]   fill;

    // configuration
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_width_reg <= PATTERN_WIDTH_RESET;
            line_width_reg    <= LINE_WIDTH_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_IDX_PATTERN_WIDTH: pattern_width_reg <= pwdata[REG_W-1:0];
                REG_IDX_LINE_WIDTH:    line_width_reg    <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_IDX_PATTERN_WIDTH: prdata = 32'(pattern_width_reg);
            REG_IDX_LINE_WIDTH:    prdata = 32'(line_width_reg);
            default:               prdata = '0;
        endcase
    end

    // effective widths
    always_comb begin
        if (line_width_reg == '0) begin
            lw_eff = CNT_W'(1);
        end else if (32'(line_width_reg) > 32'(LINE_MAX)) begin
            lw_eff = CNT_W'(LINE_MAX);
        end else begin
            lw_eff = CNT_W'(line_width_reg);
        end
        pw_nz = (pattern_width_reg == '0) ? REG_W'(1) : pattern_width_reg;
        if (32'(pw_nz) > 32'(lw_eff)) begin
            pw_eff = lw_eff;
        end else begin
            pw_eff = CNT_W'(pw_nz);
        end
    end

    // input stage: address the line store and advance the column
    assign in_depth = s_tdata[DEPTH_W-1:0];
    assign in_color = s_tdata[DEPTH_W +: COLOR_W];

    always_comb begin
        fill     = {1'b0, fifo_level} + (FIFO_CNT_W+1)'(s1_valid_reg);
        s_tready = (fill < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    end

    assign in_xfer = s_tvalid && s_tready;

    always_comb begin
        use_pattern = (CNT_W'(column_reg) < pw_eff);
        is_last     = ((CNT_W'(column_reg) + 1'b1) >= lw_eff);
        column_next = is_last ? '0 : column_reg + 1'b1;
        // wraps in pattern columns, where it is not used
        src_sum = SRC_W'(column_reg) - SRC_W'(pw_eff)
                + SRC_W'(in_depth >> DEPTH_SHIFT);
        if (src_sum >= SRC_W'(column_reg)) begin
            src_addr = column_reg - 1'b1;
        end else begin
            src_addr = src_sum[COL_W-1:0];
        end
        // the pixel in s1 writes its column at this same edge
        fwd_hit = s1_valid_reg && (src_addr == s1_col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_xfer;
            if (in_xfer) begin
                column_reg <= column_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            s1_col_reg       <= column_reg;
            s1_pattern_reg   <= use_pattern;
            s1_fwd_reg       <= fwd_hit;
            s1_last_reg      <= is_last;
            s1_pat_color_reg <= in_color;
        end
        if (s1_valid_reg) begin
            last_color_reg <= s1_color;
        end
    end

    slsh_ram #(
        .DATA_W (COLOR_W),
        .DEPTH  (LINE_MAX)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data (s1_color),
        .rd_en   (in_xfer),
        .rd_addr (src_addr),
        .rd_data (rd_color)
    );

    // second stage: pick the color, write it back, queue the result
    always_comb begin
        if (s1_pattern_reg) begin
            s1_color = s1_pat_color_reg;
        end else if (s1_fwd_reg) begin
            s1_color = last_color_reg;
        end else begin
            s1_color = rd_color;
        end
        push_item.last  = s1_last_reg;
        push_item.color = s1_color;
    end

    slsh_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_item (push_item),
        .level     (fifo_level),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .head_item (head_item)
    );

    assign m_tdata = head_item.color;
    assign m_tlast = head_item.last;

endmodule

/* verif/tb_stereogram_line_shift.sv */
`timescale 1ns / 100ps

module tb_stereogram_line_shift;

    import slsh_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 2;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // depth, pattern_red, pattern_green, pattern_blue
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // out_red, out_green, out_blue
    logic        m_tlast;         // end_of_line

    // shadow of the block: registers, line store and column
    logic [REG_W-1:0]   cfg_pattern_width;
    logic [REG_W-1:0]   cfg_line_width;
    logic [COLOR_W-1:0] line_colors_model [LINE_MAX];
    int unsigned        column_model;

    out_item_t expected_pixels [$];

    int error_count     = 0;
    int pixels_sent     = 0;
    int burst_left      = 0;
    int hold_off_cycles = 0;

    stereogram_line_shift DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    // output color of one pixel, and the line bookkeeping that goes with it
    function automatic void predict_shift(input logic [7:0] depth, red, green, blue);
        int unsigned  lw, pw, col, src;
        out_item_t    item;
        lw = cfg_line_width;
        if (lw < 1) lw = 1;
        if (lw > LINE_MAX) lw = LINE_MAX;
        pw = cfg_pattern_width;
        if (pw < 1) pw = 1;
        if (pw > lw) pw = lw;
        col = column_model;
        if (col < pw) begin
            item.color = {blue, green, red};
        end else begin
            src = col - pw + (depth >> DEPTH_SHIFT);
            if (src >= col) src = col - 1;
            item.color = line_colors_model[src];
        end
        line_colors_model[col] = item.color;
        item.last = (col + 1 >= lw);
        column_model = item.last ? 0 : col + 1;
        expected_pixels = {expected_pixels, item};
    endfunction

    function automatic logic [7:0] random_depth();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd7;
            3: return 8'd8;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic cfg_write(input logic reg_idx, input logic [11:0] value);
        logic [31:0] word;
        // upper bits are don't-care for the 12-bit registers
        word = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        word[11:0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_IDX_PATTERN_WIDTH) cfg_pattern_width = word[11:0];
        else cfg_line_width = word[11:0];
        @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [7:0] depth, red, green, blue);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {blue, green, red, depth};
        predict_shift(depth, red, green, blue);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        pixels_sent++;
    endtask

    task automatic send_random_pixel();
        send_pixel(random_depth(), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // stop offering and let every outstanding pixel come out
    task automatic wait_drained();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want, got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                $error("m_ transfer with no pixel expected: tdata %h", m_tdata);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                check_field("out_red", want.color[7:0], m_tdata[7:0]);
                check_field("out_green", want.color[15:8], m_tdata[15:8]);
                check_field("out_blue", want.color[23:16], m_tdata[23:16]);
                check_field("end_of_line", want.last, m_tlast);
            end
        end
    end

    // receiver: random stall density per segment, plus a long hold-off on request
    initial begin : result_sink
        int seg_left;
        int stall_pct;
        seg_left  = 0;
        stall_pct = 0;
        forever begin
            @(posedge aclk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_off_cycles > 0) begin
                hold_off_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic apply_reset();
        cfg_pattern_width = PATTERN_WIDTH_RESET;
        cfg_line_width    = LINE_WIDTH_RESET;
        column_model      = 0;
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
    endtask

    // depth extremes: no shift, shift past the current column, shift boundary
    task automatic test_shift_basic();
        logic [7:0] depths [8];
        depths = '{8'd0, 8'd255, 8'd8, 8'd7, 8'd0, 8'd255, 8'd248, 8'd16};
        cfg_write(REG_IDX_PATTERN_WIDTH, 12'd4);
        cfg_write(REG_IDX_LINE_WIDTH, 12'd8);
        for (int i = 0; i < 8; i++) begin
            if (i % 2 == 0) send_pixel(depths[i], 8'h00, 8'hff, 8'h00);
            else send_pixel(depths[i], 8'hff, 8'h00, 8'hff);
        end
        wait_drained();
    endtask

    task automatic test_zero_widths();
        cfg_write(REG_IDX_PATTERN_WIDTH, 12'd0);
        cfg_write(REG_IDX_LINE_WIDTH, 12'd0);
        repeat (2) send_random_pixel();
        wait_drained();
    endtask

    task automatic test_pattern_wider_than_line();
        cfg_write(REG_IDX_PATTERN_WIDTH, 12'hfff);
        cfg_write(REG_IDX_LINE_WIDTH, 12'd5);
        repeat (5) send_random_pixel();
        wait_drained();
    endtask

    // shrink the line while the column sits past the new end
    task automatic test_column_past_end();
        cfg_write(REG_IDX_PATTERN_WIDTH, 12'd2);
        cfg_write(REG_IDX_LINE_WIDTH, 12'd10);
        repeat (6) send_random_pixel();
        wait_drained();
        cfg_write(REG_IDX_LINE_WIDTH, 12'd3);
        repeat (4) send_random_pixel();
        wait_drained();
    endtask

    task automatic test_backpressure();
        cfg_write(REG_IDX_PATTERN_WIDTH, 12'd5);
        cfg_write(REG_IDX_LINE_WIDTH, 12'd16);
        hold_off_cycles = 200;
        repeat (48) send_random_pixel();
        wait_drained();
    endtask

    task automatic test_long_line();
        cfg_write(REG_IDX_PATTERN_WIDTH, 12'($urandom_range(1, 40)));
        cfg_write(REG_IDX_LINE_WIDTH, 12'hfff);
        repeat (300) send_random_pixel();
        wait_drained();
        cfg_write(REG_IDX_LINE_WIDTH, 12'd2048);
        repeat (20) send_random_pixel();
        wait_drained();
        cfg_write(REG_IDX_LINE_WIDTH, 12'd7);
        repeat (8) send_random_pixel();
        wait_drained();
    endtask

    task automatic test_random_stream();
        int unsigned lw, pw, lw_eff, count;
        while (pixels_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    lw = $urandom_range(0, 3);
                    pw = $urandom_range(0, 4);
                end
                1: begin
                    lw = $urandom_range(1, 20);
                    pw = $urandom_range(lw + 1, 4095);
                end
                default: begin
                    lw = $urandom_range(8, 48);
                    pw = $urandom_range(1, lw);
                end
            endcase
            // sometimes keep the old pattern width, and sometimes end mid-line
            if ($urandom_range(0, 3) != 0) cfg_write(REG_IDX_PATTERN_WIDTH, 12'(pw));
            cfg_write(REG_IDX_LINE_WIDTH, 12'(lw));
            lw_eff = (lw < 1) ? 1 : lw;
            count  = lw_eff * $urandom_range(1, 3) + $urandom_range(0, lw_eff);
            if (count > 150) count = 150;
            repeat (count) send_random_pixel();
            wait_drained();
        end
    endtask

    initial begin
        apply_reset();
        test_shift_basic();
        test_zero_widths();
        test_pattern_wider_than_line();
        test_column_past_end();
        test_backpressure();
        test_long_line();
        test_random_stream();
        wait_drained();
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
